// ===== rtl/core/fwv_pkg.sv =====
// package: request and result types, status codes and header constants
`timescale 1ns / 1ps

package fwv_pkg;

  localparam int unsigned HdrBytes = 6;
  localparam logic [7:0] FlagMask = 8'h03;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_FW_SUM  = 3'd2,
    ST_CFG_LEN = 3'd3,
    ST_CFG_SUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        has_config;
    logic [31:0] firmware_length;
    logic [15:0] config_length;
    logic [1:0]  update_flag;
    logic [7:0]  sub_config_count;
  } out_t;

endpackage

// ===== rtl/core/fwv_track.sv =====
// image parser: header fields, running sums, position counters and final status
`timescale 1ns / 1ps

module fwv_track (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  fwv_pkg::in_t in_i,
  output fwv_pkg::out_t res_o
);

  localparam logic [31:0] PosMax = 32'hFFFF_FFFF;
  localparam logic [16:0] OffMax = 17'h1_FFFF;
  localparam logic [32:0] HdrLast = 33'(fwv_pkg::HdrBytes - 1);

  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [15:0] bsum_q, bsum_d;
  logic [15:0] bexp_q, bexp_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] pexp_q, pexp_d;
  logic [15:0] psum_q, psum_d;
  logic [1:0]  pflag_q, pflag_d;
  logic [7:0]  pcnt_q, pcnt_d;
  logic [16:0] poff_q, poff_d;

  logic [7:0]  b;
  logic [32:0] p33;
  logic [32:0] be5;
  logic        in_hdr;
  logic        in_body;
  logic        trunc;
  logic        cfg;
  logic        clr;
  logic [16:0] plen_end;

  assign b   = in_i.data_byte;
  assign p33 = {1'b0, pos_q};
  // body end minus one: last body byte sits at length + 5
  assign be5 = {1'b0, len_q} + HdrLast;
  assign in_hdr  = p33 < 33'(fwv_pkg::HdrBytes);
  assign in_body = p33 <= be5;
  assign clr = step_i && in_i.last_byte;

  always_comb begin
    len_d   = len_q;
    bsum_d  = bsum_q;
    bexp_d  = bexp_q;
    plen_d  = plen_q;
    pexp_d  = pexp_q;
    psum_d  = psum_q;
    pflag_d = pflag_q;
    pcnt_d  = pcnt_q;
    poff_d  = poff_q;
    if (pos_q < 32'd4) begin
      len_d = {len_q[23:0], b};
    end else if (pos_q == 32'd4) begin
      bexp_d = {b, bexp_q[7:0]};
    end else if (pos_q == 32'd5) begin
      bexp_d = {bexp_q[15:8], b};
    end else if (in_body) begin
      bsum_d = bsum_q + {8'd0, b};
    end else begin
      if (poff_q == 17'd0) begin
        plen_d = {b, plen_q[7:0]};
      end else if (poff_q == 17'd1) begin
        plen_d = {plen_q[15:8], b};
      end else if (poff_q == 17'd2) begin
        pflag_d = 2'(b & fwv_pkg::FlagMask);
      end else if (poff_q == 17'd3) begin
        pcnt_d = b;
      end else if (poff_q == 17'd4) begin
        pexp_d = {b, pexp_q[7:0]};
      end else if (poff_q == 17'd5) begin
        pexp_d = {pexp_q[15:8], b};
      end else begin
        psum_d = psum_q + {8'd0, b};
      end
      // pack offset freezes with the position counter
      if (pos_q != PosMax && poff_q != OffMax) begin
        poff_d = poff_q + 17'd1;
      end
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 32'd1;
  end

  // final status, built from the values after this byte
  assign trunc    = (pos_q < 32'd5) || (p33 < be5);
  assign cfg      = !trunc && !in_body;
  assign plen_end = {1'b0, plen_d} + 17'(fwv_pkg::HdrBytes - 1);

  always_comb begin
    res_o = '0;
    if (trunc) begin
      res_o.status = fwv_pkg::ST_TRUNC;
    end else if (bsum_d != bexp_d) begin
      res_o.status = fwv_pkg::ST_FW_SUM;
    end else if (cfg && poff_q != plen_end) begin
      res_o.status = fwv_pkg::ST_CFG_LEN;
    end else if (cfg && psum_d != pexp_d) begin
      res_o.status = fwv_pkg::ST_CFG_SUM;
    end else begin
      res_o.status = fwv_pkg::ST_OK;
    end
    res_o.has_config       = cfg;
    res_o.firmware_length  = len_d;
    res_o.config_length    = cfg ? plen_d : 16'd0;
    res_o.update_flag      = cfg ? pflag_d : 2'd0;
    res_o.sub_config_count = cfg ? pcnt_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      bsum_q  <= '0;
      bexp_q  <= '0;
      plen_q  <= '0;
      pexp_q  <= '0;
      psum_q  <= '0;
      pflag_q <= '0;
      pcnt_q  <= '0;
      poff_q  <= '0;
    end else if (clr) begin
      pos_q   <= '0;
      len_q   <= '0;
      bsum_q  <= '0;
      bexp_q  <= '0;
      plen_q  <= '0;
      pexp_q  <= '0;
      psum_q  <= '0;
      pflag_q <= '0;
      pcnt_q  <= '0;
      poff_q  <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      bsum_q  <= bsum_d;
      bexp_q  <= bexp_d;
      plen_q  <= plen_d;
      pexp_q  <= pexp_d;
      psum_q  <= psum_d;
      pflag_q <= pflag_d;
      pcnt_q  <= pcnt_d;
      poff_q  <= poff_d;
    end
  end

  // a finished image leaves the parser at the start of a new one
  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (pos_q == 32'd0 && poff_q == 17'd0 && bsum_q == 16'd0))
    else $error("parser state not cleared after final byte");

  // pack offset only moves once the body is behind us
  a_poff_after_body : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !in_i.last_byte && (in_hdr || in_body)) |=> $stable(poff_q))
    else $error("pack offset moved inside header or body");

  // the result never claims a config pack on a truncated image
  a_trunc_no_cfg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.status == fwv_pkg::ST_TRUNC) |-> !res_o.has_config)
    else $error("truncated image reported with config pack");

endmodule

// ===== rtl/core/firmware_image_stream_validator.sv =====
// top level: request register, image parser and result register
//
//  channel | signals                           | direction | content
//  --------+-----------------------------------+-----------+---------------------------
//  in      | in_valid_i  in_ready_o  in_data_i | to block  | one image byte, last flag
//  out     | out_valid_o out_ready_i out_data_o| from block| status and header fields
//
// one image byte is taken per cycle; the parser works in the cycle after the
// request register loads, and the status is registered when the final byte advances.
// reset clears both stages and the parser, which starts at image offset zero.
// a held result only stalls a final byte: ordinary bytes keep flowing while
// the result register waits, so the input stalls only behind a second final byte.
`timescale 1ns / 1ps

module firmware_image_stream_validator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fwv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fwv_pkg::out_t out_data_o
);

  logic          s1_valid_q, s1_valid_d;
  fwv_pkg::in_t  s1_q;
  logic          out_valid_q, out_valid_d;
  fwv_pkg::out_t out_q;
  fwv_pkg::out_t res;
  logic          in_acc;
  logic          s1_adv;
  logic          out_load;

  // only a final byte needs a free result slot
  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = s1_adv && s1_q.last_byte;

  fwv_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .in_i   (s1_q),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // backpressure only ever comes from a loaded request stage
  a_ready_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_q.last_byte && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked final byte");

  // a result is produced only by a final byte
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q && s1_q.last_byte))
    else $error("result appeared without a final byte");

  // a waiting result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("result register loaded while holding an untaken result");

endmodule

// ===== sim/image_status_checker.sv =====
// checker: predicts the status report of every image and compares it with the block output
`timescale 1ns / 1ps

module image_status_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  fwv_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  fwv_pkg::out_t out_data_i,
  output int unsigned   errors_o,
  output int unsigned   pending_o,
  output int unsigned   reports_o,
  output int unsigned   config_reports_o
);

  localparam int unsigned ShowLimit = 10;

  logic [31:0] img_pos;
  logic [31:0] fw_len;
  logic [15:0] fw_sum;
  logic [15:0] fw_sum_want;
  logic [15:0] pk_len;
  logic [15:0] pk_sum_want;
  logic [15:0] pk_sum;
  logic [1:0]  pk_flags;
  logic [7:0]  pk_count;

  fwv_pkg::out_t status_reports_q[$];

  task automatic clear_parser();
    img_pos     = '0;
    fw_len      = '0;
    fw_sum      = '0;
    fw_sum_want = '0;
    pk_len      = '0;
    pk_sum_want = '0;
    pk_sum      = '0;
    pk_flags    = '0;
    pk_count    = '0;
  endtask

  task automatic parse_image_byte(input fwv_pkg::in_t req);
    logic [63:0]   pos;
    logic [63:0]   body_end;
    logic [63:0]   total;
    logic [63:0]   ofs;
    logic [7:0]    b;
    fwv_pkg::out_t rep;
    b        = req.data_byte;
    pos      = {32'd0, img_pos};
    body_end = {32'd0, fw_len} + 64'(fwv_pkg::HdrBytes);
    if (pos < 64'd4) begin
      fw_len = {fw_len[23:0], b};
    end else if (pos == 64'd4) begin
      fw_sum_want[15:8] = b;
    end else if (pos == 64'd5) begin
      fw_sum_want[7:0] = b;
    end else if (pos < body_end) begin
      fw_sum = fw_sum + 16'(b);
    end else begin
      ofs = pos - body_end;
      case (ofs)
        64'd0: pk_len[15:8] = b;
        64'd1: pk_len[7:0] = b;
        64'd2: pk_flags = 2'(b & fwv_pkg::FlagMask);
        64'd3: pk_count = b;
        64'd4: pk_sum_want[15:8] = b;
        64'd5: pk_sum_want[7:0] = b;
        default: pk_sum = pk_sum + 16'(b);
      endcase
    end
    // position sticks at all ones on very long images
    if (img_pos != '1) img_pos = img_pos + 32'd1;

    if (req.last_byte) begin
      total    = pos + 64'd1;
      body_end = {32'd0, fw_len} + 64'(fwv_pkg::HdrBytes);
      rep      = '0;
      rep.firmware_length = fw_len;
      if (total < 64'(fwv_pkg::HdrBytes) || total < body_end) begin
        rep.status = fwv_pkg::ST_TRUNC;
      end else begin
        rep.has_config = (total > body_end);
        if (fw_sum != fw_sum_want) begin
          rep.status = fwv_pkg::ST_FW_SUM;
        end else if (rep.has_config) begin
          if (total - body_end != {48'd0, pk_len} + 64'(fwv_pkg::HdrBytes)) begin
            rep.status = fwv_pkg::ST_CFG_LEN;
          end else if (pk_sum != pk_sum_want) begin
            rep.status = fwv_pkg::ST_CFG_SUM;
          end else begin
            rep.status = fwv_pkg::ST_OK;
          end
        end else begin
          rep.status = fwv_pkg::ST_OK;
        end
        if (rep.has_config) begin
          rep.config_length    = pk_len;
          rep.update_flag      = pk_flags;
          rep.sub_config_count = pk_count;
        end
      end
      status_reports_q.push_back(rep);
      clear_parser();
    end
  endtask

  task automatic check_report(input fwv_pkg::out_t got);
    fwv_pkg::out_t want;
    reports_o++;
    if (got.has_config) config_reports_o++;
    if (status_reports_q.size() == 0) begin
      errors_o++;
      if (errors_o <= ShowLimit)
        $display("%0t: status report %0d arrived with no image pending",
                 $realtime, reports_o);
      return;
    end
    want = status_reports_q.pop_front();
    if (got.status !== want.status || got.has_config !== want.has_config ||
        got.firmware_length !== want.firmware_length ||
        got.config_length !== want.config_length ||
        got.update_flag !== want.update_flag ||
        got.sub_config_count !== want.sub_config_count) begin
      errors_o++;
      if (errors_o <= ShowLimit) begin
        $display("%0t: report %0d exp st=%0d cfg=%0b fw=%h cl=%h uf=%0d sc=%h",
                 $realtime, reports_o,
                 want.status, want.has_config, want.firmware_length, want.config_length,
                 want.update_flag, want.sub_config_count);
        $display("%0t: report %0d got st=%0d cfg=%0b fw=%h cl=%h uf=%0d sc=%h",
                 $realtime, reports_o,
                 got.status, got.has_config, got.firmware_length, got.config_length,
                 got.update_flag, got.sub_config_count);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      status_reports_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_report(out_data_i);
      if (in_valid_i && in_ready_i) parse_image_byte(in_data_i);
    end
    pending_o = status_reports_q.size();
  end

endmodule

// ===== sim/firmware_image_stream_validator_test.sv =====
// testbench top: image stimulus, output stalls, timeout and verdict
`timescale 1ns / 1ps

module firmware_image_stream_validator_test;

  localparam int unsigned ByteBudget  = 1800;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxGap      = 13;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {
    IMG_GOOD,
    IMG_BAD_FW_SUM,
    IMG_BAD_PACK,
    IMG_CUT,
    IMG_EXTRA,
    IMG_NOISE
  } image_flavor_e;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid = 1'b0;
  logic          in_ready;
  fwv_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  fwv_pkg::out_t out_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned reports;
  int unsigned config_reports;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned images_sent;
  bit          in_burst;
  bit          out_burst;
  logic [7:0]  img[$];

  always #5 clk = ~clk;

  firmware_image_stream_validator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  image_status_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .errors_o         (errors),
    .pending_o        (pending),
    .reports_o        (reports),
    .config_reports_o (config_reports)
  );

  task automatic send_image();
    fwv_pkg::in_t req;
    int unsigned  gap;
    in_burst = ($urandom_range(0, 3) == 0);
    foreach (img[i]) begin
      gap = in_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req.data_byte = img[i];
      req.last_byte = (i == img.size() - 1);
      in_valid <= 1'b1;
      in_data  <= req;
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
    end
    images_sent++;
  endtask

  task automatic make_image();
    image_flavor_e flavor;
    int unsigned   pick;
    int unsigned   body_n;
    int unsigned   pack_n;
    int unsigned   n;
    logic [31:0]   body_len;
    logic [15:0]   pk_len_field;
    logic [15:0]   sum;
    logic [7:0]    b;
    bit            with_pack;
    pick   = $urandom_range(0, 9);
    flavor = (pick < 5) ? IMG_GOOD : image_flavor_e'(pick - 4);
    img.delete();
    if (flavor == IMG_NOISE) begin
      n = $urandom_range(1, 24);
      repeat (n) img.push_back(8'($urandom));
      return;
    end

    // mostly short bodies, a few longer ones
    body_n   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 16);
    body_len = 32'(body_n);
    img.push_back(body_len[31:24]);
    img.push_back(body_len[23:16]);
    img.push_back(body_len[15:8]);
    img.push_back(body_len[7:0]);
    img.push_back(8'h00);
    img.push_back(8'h00);
    sum = '0;
    repeat (body_n) begin
      b = 8'($urandom);
      sum = sum + 16'(b);
      img.push_back(b);
    end
    img[4] = sum[15:8];
    img[5] = sum[7:0];

    with_pack = $urandom_range(0, 1);
    if (with_pack) begin
      pack_n       = $urandom_range(0, 12);
      pk_len_field = 16'(pack_n);
      img.push_back(pk_len_field[15:8]);
      img.push_back(pk_len_field[7:0]);
      img.push_back(8'($urandom));
      img.push_back(8'($urandom));
      img.push_back(8'h00);
      img.push_back(8'h00);
      sum = '0;
      repeat (pack_n) begin
        b = 8'($urandom);
        sum = sum + 16'(b);
        img.push_back(b);
      end
      img[body_n + 10] = sum[15:8];
      img[body_n + 11] = sum[7:0];
    end

    case (flavor)
      IMG_BAD_FW_SUM: begin
        n = $urandom_range(4, 5);
        img[n] = img[n] ^ 8'($urandom_range(1, 255));
      end
      IMG_BAD_PACK: begin
        if (with_pack) begin
          // hit either the pack length or the pack checksum
          n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(4, 5);
          img[body_n + 6 + n] = img[body_n + 6 + n] ^ 8'($urandom_range(1, 255));
        end else begin
          n = $urandom_range(1, 5);
          repeat (n) img.push_back(8'($urandom));
        end
      end
      IMG_CUT: begin
        if (img.size() > 1) begin
          n = $urandom_range(1, img.size() - 1);
          while (img.size() > n) void'(img.pop_back());
        end
      end
      IMG_EXTRA: begin
        n = $urandom_range(1, 8);
        repeat (n) img.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  // result side stalls, with occasional runs of constant readiness
  initial begin
    int unsigned stall;
    int unsigned served;
    served = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (served % 16 == 0) out_burst = ($urandom_range(0, 2) == 0);
      stall = out_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports still pending", cycle_count, pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte, header cut short
    img = {8'hFF};
    send_image();
    // empty body, zero checksum
    img = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_image();
    // maximum body length, body missing
    img = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
    send_image();
    // empty body with a nonzero checksum
    img = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    send_image();
    // config pack shorter than its own header
    img = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAB, 8'hCD};
    send_image();

    while (bytes_sent < ByteBudget) begin
      make_image();
      send_image();
    end
    in_valid <= 1'b0;

    // let the checker see the final request before waiting on its report
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d images in %0d bytes with random gaps and output stalls",
             images_sent, bytes_sent);
    $display("compared %0d status reports, %0d of them with a config pack",
             reports, config_reports);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d reports missing", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
